// ===== rtl/core/hquick_flux_limiter_unit_assert.svh =====
// assertion macros shared by the flux limiter rtl
// all of them sample on i_clk; the first two are muted while i_rst_n is low
`ifndef HQUICK_FLUX_LIMITER_UNIT_ASSERT_SVH
`define HQUICK_FLUX_LIMITER_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define HQFL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define HQFL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also watches the reset itself
`define HQFL_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hqfl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hqfl_pkg
// Shared widths and the control bundle passed along the divider cells.
// ----------------------------------------------------------------------------
package hqfl_pkg;

    // width of every fixed-point field on the ports
    localparam int DATA_W = 32;
    // divisor width: 3*2^F + r stays below 2^33 for any legal fraction width
    localparam int DEN_W  = DATA_W + 1;
    // input beat carries ratio and gradient side by side
    localparam int IN_W   = 2 * DATA_W;

    // control that rides along with each item through the cells
    typedef struct packed {
        logic valid;
        logic ratio_pos;
    } t_cell_ctl;

endpackage

// ===== rtl/core/hquick_flux_limiter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hquick_flux_limiter_unit
// HQUICK TVD limiter: scales a gradient by phi(r) = 4r/(3+r), optionally
// bounded by 2/(1+r), in signed fixed point with saturation.
// ----------------------------------------------------------------------------
// One component per beat, one result per beat. A new beat is taken every
// cycle while the output is not held. The pipe has FRAC_BITS+2 division
// cells, each resolving one quotient bit of both phi terms, then phi select,
// multiply and round/saturate stages. The whole pipe advances together, so
// the input stalls only while a finished result waits on the output. The
// bound enable is a one-bit register written over the cfg channel, reset to
// 1; write it only while the unit is empty.
`include "hquick_flux_limiter_unit_assert.svh"

module hquick_flux_limiter_unit
    import hqfl_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write
    input  logic              i_cfg_valid,
    input  logic              i_cfg_data,   // second_order_bound_on
    output logic              o_cfg_ready,
    // input stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_W-1:0]   i_s_tdata,    // [31:0] slope_ratio, [63:32] gradient_value
    // result stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,    // [31:0] limited_gradient
    output logic [0:0]        o_m_tuser     // [0] saturated
);

    localparam int QW = FRAC_BITS + 2;

    logic r_bound_on;
    logic advance;
    logic out_valid;

    logic signed [DATA_W-1:0] in_ratio, in_grad;
    logic                     in_pos;
    logic [DEN_W-1:0]         in_r;

    t_cell_ctl                ctl  [QW+1];
    logic [DEN_W-1:0]         rem_m[QW+1];
    logic [DEN_W-1:0]         rem_b[QW+1];
    logic [DEN_W-1:0]         den_m[QW+1];
    logic [DEN_W-1:0]         den_b[QW+1];
    logic [QW-1:0]            q_m  [QW+1];
    logic [QW-1:0]            q_b  [QW+1];
    logic signed [DATA_W-1:0] grad [QW+1];

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_on <= 1'b1;
        end else if (i_cfg_valid) begin
            r_bound_on <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    // whole pipe moves unless the output beat is held
    assign advance    = !out_valid || i_m_tready;
    assign o_s_tready = advance;

    // division setup: initial remainders are the dividends with the
    // all-zero low quotient-width bits dropped
    always_comb begin
        in_ratio        = i_s_tdata[DATA_W-1:0];
        in_grad         = i_s_tdata[IN_W-1:DATA_W];
        in_pos          = !in_ratio[DATA_W-1] && (in_ratio != '0);
        in_r            = in_pos ? {2'b00, in_ratio[DATA_W-2:0]} : '0;
        ctl[0].valid     = i_s_tvalid;
        ctl[0].ratio_pos = in_pos;
        rem_m[0]        = in_r;
        rem_b[0]        = {{(DEN_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
        den_m[0]        = (DEN_W'(3) << FRAC_BITS) + in_r;
        den_b[0]        = ({{(DEN_W-1){1'b0}}, 1'b1} << FRAC_BITS) + in_r;
        q_m[0]          = '0;
        q_b[0]          = '0;
        grad[0]         = in_grad;
    end

    // chain of division cells
    for (genvar k = 0; k < QW; k++) begin : g_cell
        hqfl_div_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_ctl   (ctl[k]),
            .i_rem_m (rem_m[k]),
            .i_rem_b (rem_b[k]),
            .i_den_m (den_m[k]),
            .i_den_b (den_b[k]),
            .i_q_m   (q_m[k]),
            .i_q_b   (q_b[k]),
            .i_grad  (grad[k]),
            .o_ctl   (ctl[k+1]),
            .o_rem_m (rem_m[k+1]),
            .o_rem_b (rem_b[k+1]),
            .o_den_m (den_m[k+1]),
            .o_den_b (den_b[k+1]),
            .o_q_m   (q_m[k+1]),
            .o_q_b   (q_b[k+1]),
            .o_grad  (grad[k+1])
        );
    end

    // phi select, multiply, round and saturate
    hqfl_mul_sat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_sat (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_bound_on (r_bound_on),
        .i_ctl      (ctl[QW]),
        .i_q_m      (q_m[QW]),
        .i_q_b      (q_b[QW]),
        .i_grad     (grad[QW]),
        .o_valid    (out_valid),
        .o_data     (o_m_tdata),
        .o_sat      (o_m_tuser[0])
    );

    assign o_m_tvalid = out_valid;

    // a clipped beat carries one of the two range limits
    `HQFL_ASSERT_NOW(a_sat_value, o_m_tvalid && o_m_tuser[0],
        (o_m_tdata == 32'h7FFF_FFFF) || (o_m_tdata == 32'h8000_0000),
        "saturated beat without a limit value")
    // a held result blocks new input
    `HQFL_ASSERT_NOW(a_stall_blocks_input, o_m_tvalid && !i_m_tready, !o_s_tready,
        "input taken while output stalled")
    // pipe empties on reset
    `HQFL_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_m_tvalid,
        "result valid right after reset")
    // ready is only dropped by a pending result
    `HQFL_ASSERT_NOW(a_ready_when_drained, !o_m_tvalid, o_s_tready,
        "input not ready with empty output")

endmodule

// ===== rtl/core/hqfl_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hqfl_div_cell
// One restoring-division step for both limiter quotients: the main term
// 4r/(3+r) and the second-order bound 2/(1+r), one quotient bit each.
// ----------------------------------------------------------------------------
`include "hquick_flux_limiter_unit_assert.svh"

module hqfl_div_cell
    import hqfl_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_cell_ctl                i_ctl,
    input  logic [DEN_W-1:0]         i_rem_m,
    input  logic [DEN_W-1:0]         i_rem_b,
    input  logic [DEN_W-1:0]         i_den_m,
    input  logic [DEN_W-1:0]         i_den_b,
    input  logic [FRAC_BITS+1:0]     i_q_m,
    input  logic [FRAC_BITS+1:0]     i_q_b,
    input  logic signed [DATA_W-1:0] i_grad,
    output t_cell_ctl                o_ctl,
    output logic [DEN_W-1:0]         o_rem_m,
    output logic [DEN_W-1:0]         o_rem_b,
    output logic [DEN_W-1:0]         o_den_m,
    output logic [DEN_W-1:0]         o_den_b,
    output logic [FRAC_BITS+1:0]     o_q_m,
    output logic [FRAC_BITS+1:0]     o_q_b,
    output logic signed [DATA_W-1:0] o_grad
);

    localparam int QW = FRAC_BITS + 2;

    t_cell_ctl                r_ctl;
    logic [DEN_W-1:0]         r_rem_m, n_rem_m;
    logic [DEN_W-1:0]         r_rem_b, n_rem_b;
    logic [DEN_W-1:0]         r_den_m;
    logic [DEN_W-1:0]         r_den_b;
    logic [QW-1:0]            r_q_m, n_q_m;
    logic [QW-1:0]            r_q_b, n_q_b;
    logic signed [DATA_W-1:0] r_grad;

    logic [DEN_W:0] sh_m, sh_b;
    logic [DEN_W:0] diff_m, diff_b;
    logic           ge_m, ge_b;

    // shift in a zero dividend bit, trial subtract, keep on no borrow
    always_comb begin
        sh_m    = {i_rem_m, 1'b0};
        sh_b    = {i_rem_b, 1'b0};
        diff_m  = sh_m - {1'b0, i_den_m};
        diff_b  = sh_b - {1'b0, i_den_b};
        ge_m    = (sh_m >= {1'b0, i_den_m});
        ge_b    = (sh_b >= {1'b0, i_den_b});
        n_rem_m = ge_m ? diff_m[DEN_W-1:0] : sh_m[DEN_W-1:0];
        n_rem_b = ge_b ? diff_b[DEN_W-1:0] : sh_b[DEN_W-1:0];
        n_q_m   = {i_q_m[QW-2:0], ge_m};
        n_q_b   = {i_q_b[QW-2:0], ge_b};
    end

    // item valid and positive-ratio flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // payload stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_m <= n_rem_m;
            r_rem_b <= n_rem_b;
            r_den_m <= i_den_m;
            r_den_b <= i_den_b;
            r_q_m   <= n_q_m;
            r_q_b   <= n_q_b;
            r_grad  <= i_grad;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_rem_m = r_rem_m;
    assign o_rem_b = r_rem_b;
    assign o_den_m = r_den_m;
    assign o_den_b = r_den_b;
    assign o_q_m   = r_q_m;
    assign o_q_b   = r_q_b;
    assign o_grad  = r_grad;

    // partial remainders always stay below their divisors, and the main divisor stays above the bound divisor
    `HQFL_ASSERT_NOW(a_rem_main_lt_den, r_ctl.valid, r_rem_m < r_den_m,
        "main remainder reached its divisor")
    `HQFL_ASSERT_NOW(a_rem_bound_lt_den, r_ctl.valid, r_rem_b < r_den_b,
        "bound remainder reached its divisor")
    `HQFL_ASSERT_NOW(a_den_order, r_ctl.valid, r_den_m > r_den_b,
        "main divisor not above bound divisor")

endmodule

// ===== rtl/core/hqfl_mul_sat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hqfl_mul_sat
// Picks phi from the two quotients, scales the gradient by it, then rounds
// to nearest and saturates to the signed 32-bit range.
// ----------------------------------------------------------------------------
module hqfl_mul_sat
    import hqfl_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_bound_on,
    input  t_cell_ctl                i_ctl,
    input  logic [FRAC_BITS+1:0]     i_q_m,
    input  logic [FRAC_BITS+1:0]     i_q_b,
    input  logic signed [DATA_W-1:0] i_grad,
    output logic                     o_valid,
    output logic [DATA_W-1:0]        o_data,
    output logic                     o_sat
);

    localparam int QW = FRAC_BITS + 2;
    localparam int PW = DATA_W + QW + 1;
    localparam int RW = PW - FRAC_BITS;
    localparam logic signed [PW-1:0] HALF_LSB = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic                     r_v_phi, r_v_prod, r_v_out;
    logic [QW-1:0]            r_phi, n_phi;
    logic signed [DATA_W-1:0] r_grad;
    logic signed [PW-1:0]     r_prod, n_prod;
    logic [DATA_W-1:0]        r_data, n_data;
    logic                     r_sat, n_sat;

    logic [QW-1:0]        q_min;
    logic signed [QW:0]   phi_s;
    logic signed [PW-1:0] rounded;
    logic signed [RW-1:0] res;
    logic                 over_hi, over_lo;

    // phi select: zero for a non-positive ratio, else main term or its bound
    always_comb begin
        q_min = (i_bound_on && (i_q_b < i_q_m)) ? i_q_b : i_q_m;
        n_phi = i_ctl.ratio_pos ? q_min : '0;
    end

    // product of phi and gradient, exact
    always_comb begin
        phi_s  = $signed({1'b0, r_phi});
        n_prod = phi_s * r_grad;
    end

    // round half up, floor shift, clip to 32 bits
    always_comb begin
        rounded = r_prod + HALF_LSB;
        res     = RW'(rounded >>> FRAC_BITS);
        over_hi = !res[RW-1] && (res[RW-2:DATA_W-1] != '0);
        over_lo = res[RW-1] && (res[RW-2:DATA_W-1] != '1);
        n_sat   = over_hi || over_lo;
        if (over_hi) begin
            n_data = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (over_lo) begin
            n_data = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            n_data = res[DATA_W-1:0];
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_phi  <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_out  <= 1'b0;
        end else if (i_en) begin
            r_v_phi  <= i_ctl.valid;
            r_v_prod <= r_v_phi;
            r_v_out  <= r_v_prod;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phi  <= n_phi;
            r_grad <= i_grad;
            r_prod <= n_prod;
            r_data <= n_data;
            r_sat  <= n_sat;
        end
    end

    assign o_valid = r_v_out;
    assign o_data  = r_data;
    assign o_sat   = r_sat;

endmodule
